FILE: rtl/uv_sphere_mesh_generator_macros.svh
// Assertion macros for the UV sphere mesh generator.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef UV_SPHERE_MESH_GENERATOR_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define UVS_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("uv sphere check failed");
// The consequent must hold in the cycle after the antecedent.
`define UVS_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("uv sphere check failed");
`else
`define UVS_ASSERT_NOW(label, ck, rn, ante, cons)
`define UVS_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

FILE: rtl/uvs_pkg.sv
package uvs_pkg;

  // Field widths.
  localparam int ROW_W     = 9;
  localparam int COL_W     = 9;
  localparam int RADIUS_W  = 16;
  localparam int COUNT_W   = 9;
  localparam int STEP_W    = 16;
  localparam int IDX_W     = 17;
  localparam int POS_W     = 16;
  localparam int NORM_W    = 16;

  // Sine table entries are unsigned Q30 magnitudes.
  localparam int FRAC      = 30;
  localparam int MAG_W     = 31;
  localparam int SIG_W     = 32;
  localparam int MUL_W     = 62;

  // Polynomial coefficients of the quarter-wave sine, Q30.
  localparam logic [MAG_W-1:0] C1 = 31'd1686629713;
  localparam logic [MAG_W-1:0] C3 = 31'd693598669;
  localparam logic [MAG_W-1:0] C5 = 31'd85569306;
  localparam logic [MAG_W-1:0] C7 = 31'd5026995;
  localparam logic [MAG_W-1:0] C9 = 31'd172272;

  // Saturation bounds.
  localparam logic signed [63:0] POS_LO  = -64'sd32768;
  localparam logic signed [63:0] POS_HI  = 64'sd32767;
  localparam logic signed [63:0] NORM_LO = -64'sd16384;
  localparam logic signed [63:0] NORM_HI = 64'sd16384;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_RADIUS      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECTORS     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STACKS      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SECTOR_STEP = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STACK_STEP  = 3'd4;

  localparam logic [RADIUS_W-1:0] RADIUS_RST      = 16'd4096;
  localparam logic [COUNT_W-1:0]  SECTORS_RST     = 9'd36;
  localparam logic [COUNT_W-1:0]  STACKS_RST      = 9'd18;
  localparam logic [STEP_W-1:0]   SECTOR_STEP_RST = 16'd1820;
  localparam logic [STEP_W-1:0]   STACK_STEP_RST  = 16'd1820;

  // Mesh connectivity of one grid point.
  typedef struct packed {
    logic [IDX_W-1:0] upper_index;
    logic [IDX_W-1:0] lower_index;
    logic [IDX_W-1:0] upper_next;
    logic [IDX_W-1:0] lower_next;
    logic             top_tri_valid;
    logic             bottom_tri_valid;
  } mesh_idx_t;

endpackage

FILE: rtl/uv_sphere_mesh_generator.sv
// UV sphere mesh generator. Each input transaction names one grid point (stack row, sector
// column); the block returns one output transaction with the sphere vertex (Q3.12), its unit
// normal (Q1.14), the four corner indices of the quad that starts there and two flags telling
// which of the quad's triangles exist. Angles are binary phases where 2^ANGLE_BITS is a full
// turn; the stack angle is a quarter turn minus row * stack_step and the sector angle is
// column * sector_step. Sine and cosine come from a quarter-wave table of
// 2^(ANGLE_BITS-2)+1 entries, held twice so that the two stack lookups and the two sector
// lookups each use the two read ports of one memory. After reset the table is computed by
// a shared multiplier that evaluates the sine polynomial step by step for each entry, so
// the block accepts no transaction until the last entry is written; configuration writes
// are taken during that time. Afterwards the block accepts one grid point every cycle
// unless a stalled output holds the pipeline; each result passes the pipeline stages and
// the output register before out_valid rises. The output register parts the two channels: a
// new transaction is taken while a finished result waits, as long as the last pipeline stage
// has room. The configuration registers may only be written while the block is idle.
`include "uv_sphere_mesh_generator_macros.svh"
module uv_sphere_mesh_generator #(
  parameter int MAX_SECTORS = 256,
  parameter int MAX_STACKS  = 256,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration port.
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [uvs_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [uvs_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [uvs_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready,
  // Grid point input.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [uvs_pkg::ROW_W-1:0]            in_row,
  input  logic [uvs_pkg::COL_W-1:0]            in_column,
  // Vertex output.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [uvs_pkg::POS_W-1:0]     out_pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]     out_pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]     out_pos_z,
  output logic signed [uvs_pkg::NORM_W-1:0]    out_norm_x,
  output logic signed [uvs_pkg::NORM_W-1:0]    out_norm_y,
  output logic signed [uvs_pkg::NORM_W-1:0]    out_norm_z,
  output logic [uvs_pkg::IDX_W-1:0]            out_upper_index,
  output logic [uvs_pkg::IDX_W-1:0]            out_lower_index,
  output logic [uvs_pkg::IDX_W-1:0]            out_upper_next,
  output logic [uvs_pkg::IDX_W-1:0]            out_lower_next,
  output logic                                 out_top_tri_valid,
  output logic                                 out_bottom_tri_valid
);

  // Table address width covers the quarter-wave range 0 .. 2^(ANGLE_BITS-2) inclusive.
  localparam int QTR_W     = ANGLE_BITS - 1;
  localparam int TBL_DEPTH = (1 << (ANGLE_BITS - 2)) + 1;
  localparam int PH_PROD_W = uvs_pkg::ROW_W + uvs_pkg::STEP_W;
  localparam logic [QTR_W-1:0] LAST_ADDR = QTR_W'(1 << (ANGLE_BITS - 2));

  localparam logic [ANGLE_BITS:0] FULL_PH = {1'b1, {ANGLE_BITS{1'b0}}};
  localparam logic [ANGLE_BITS:0] HALF_PH = FULL_PH >> 1;
  localparam logic [ANGLE_BITS:0] QTR_PH  = FULL_PH >> 2;
  localparam logic [PH_PROD_W-1:0] QTR_PH_W = PH_PROD_W'(QTR_PH);

  // Steps of the table fill sequencer.
  localparam logic [2:0] FS_SQUARE = 3'd0;
  localparam logic [2:0] FS_C9     = 3'd1;
  localparam logic [2:0] FS_C7     = 3'd2;
  localparam logic [2:0] FS_C5     = 3'd3;
  localparam logic [2:0] FS_C3     = 3'd4;
  localparam logic [2:0] FS_C1     = 3'd5;
  localparam logic [2:0] FS_WRITE  = 3'd6;

  // ---------------------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so a write completes in the access cycle.
  // ---------------------------------------------------------------------------------------
  logic [uvs_pkg::RADIUS_W-1:0] radius_r;
  logic [uvs_pkg::COUNT_W-1:0]  sector_count_r;
  logic [uvs_pkg::COUNT_W-1:0]  stack_count_r;
  logic [uvs_pkg::STEP_W-1:0]   sector_step_r;
  logic [uvs_pkg::STEP_W-1:0]   stack_step_r;
  logic                         cfg_wr;
  logic [uvs_pkg::REG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[uvs_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r       <= uvs_pkg::RADIUS_RST;
      sector_count_r <= uvs_pkg::SECTORS_RST;
      stack_count_r  <= uvs_pkg::STACKS_RST;
      sector_step_r  <= uvs_pkg::SECTOR_STEP_RST;
      stack_step_r   <= uvs_pkg::STACK_STEP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        uvs_pkg::REG_RADIUS:      radius_r       <= cfg_pwdata[uvs_pkg::RADIUS_W-1:0];
        uvs_pkg::REG_SECTORS:     sector_count_r <= cfg_pwdata[uvs_pkg::COUNT_W-1:0];
        uvs_pkg::REG_STACKS:      stack_count_r  <= cfg_pwdata[uvs_pkg::COUNT_W-1:0];
        uvs_pkg::REG_SECTOR_STEP: sector_step_r  <= cfg_pwdata[uvs_pkg::STEP_W-1:0];
        uvs_pkg::REG_STACK_STEP:  stack_step_r   <= cfg_pwdata[uvs_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      uvs_pkg::REG_RADIUS:      cfg_prdata = uvs_pkg::CFG_DATA_W'(radius_r);
      uvs_pkg::REG_SECTORS:     cfg_prdata = uvs_pkg::CFG_DATA_W'(sector_count_r);
      uvs_pkg::REG_STACKS:      cfg_prdata = uvs_pkg::CFG_DATA_W'(stack_count_r);
      uvs_pkg::REG_SECTOR_STEP: cfg_prdata = uvs_pkg::CFG_DATA_W'(sector_step_r);
      uvs_pkg::REG_STACK_STEP:  cfg_prdata = uvs_pkg::CFG_DATA_W'(stack_step_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // A count of zero behaves as one, a count above the maximum as the maximum.
  logic [uvs_pkg::COUNT_W-1:0] sectors;
  logic [uvs_pkg::COUNT_W-1:0] stacks;

  always_comb begin
    if (sector_count_r == '0) begin
      sectors = uvs_pkg::COUNT_W'(1);
    end else if (int'(sector_count_r) > MAX_SECTORS) begin
      sectors = uvs_pkg::COUNT_W'(MAX_SECTORS);
    end else begin
      sectors = sector_count_r;
    end
    if (stack_count_r == '0) begin
      stacks = uvs_pkg::COUNT_W'(1);
    end else if (int'(stack_count_r) > MAX_STACKS) begin
      stacks = uvs_pkg::COUNT_W'(MAX_STACKS);
    end else begin
      stacks = stack_count_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Table fill after reset. One multiplier is shared by all steps of the Horner evaluation:
  // square the angle, then four coefficient steps on a^2, then the final product with a.
  // Every product is registered before the next subtraction and multiplication.
  // ---------------------------------------------------------------------------------------
  logic                        fill_busy_r, fill_busy_nxt;
  logic [2:0]                  fill_step_r, fill_step_nxt;
  logic [QTR_W-1:0]            fill_addr_r, fill_addr_nxt;
  logic [uvs_pkg::MUL_W-1:0]   fill_prod_r, fill_prod_nxt;
  logic [uvs_pkg::MAG_W-1:0]   fill_a2_r, fill_a2_nxt;
  logic [uvs_pkg::MAG_W-1:0]   fill_a;
  logic [uvs_pkg::MAG_W-1:0]   prod_shr;
  logic [uvs_pkg::MAG_W-1:0]   op_a, op_b;
  logic                        tbl_we;

  // Angle magnitude in Q30: the table address scaled to a 32-bit phase.
  assign fill_a   = {fill_addr_r, {(32 - ANGLE_BITS){1'b0}}};
  assign prod_shr = fill_prod_r[uvs_pkg::FRAC +: uvs_pkg::MAG_W];
  assign tbl_we   = fill_busy_r && (fill_step_r == FS_WRITE);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (fill_step_r)
      FS_SQUARE: begin
        op_a = fill_a;
        op_b = fill_a;
      end
      FS_C9: begin
        op_a = uvs_pkg::C9;
        op_b = prod_shr;
      end
      FS_C7: begin
        op_a = uvs_pkg::C7 - prod_shr;
        op_b = fill_a2_r;
      end
      FS_C5: begin
        op_a = uvs_pkg::C5 - prod_shr;
        op_b = fill_a2_r;
      end
      FS_C3: begin
        op_a = uvs_pkg::C3 - prod_shr;
        op_b = fill_a2_r;
      end
      FS_C1: begin
        op_a = uvs_pkg::C1 - prod_shr;
        op_b = fill_a;
      end
      default: ;
    endcase
  end

  always_comb begin
    fill_busy_nxt = fill_busy_r;
    fill_step_nxt = fill_step_r;
    fill_addr_nxt = fill_addr_r;
    fill_a2_nxt   = fill_a2_r;
    fill_prod_nxt = uvs_pkg::MUL_W'(op_a) * uvs_pkg::MUL_W'(op_b);
    if (fill_busy_r) begin
      if (fill_step_r == FS_C9) begin
        fill_a2_nxt = prod_shr;
      end
      if (fill_step_r == FS_WRITE) begin
        fill_step_nxt = FS_SQUARE;
        if (fill_addr_r == LAST_ADDR) begin
          fill_busy_nxt = 1'b0;
        end else begin
          fill_addr_nxt = fill_addr_r + QTR_W'(1);
        end
      end else begin
        fill_step_nxt = fill_step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_step_r <= FS_SQUARE;
      fill_addr_r <= '0;
    end else begin
      fill_busy_r <= fill_busy_nxt;
      fill_step_r <= fill_step_nxt;
      fill_addr_r <= fill_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_prod_r <= fill_prod_nxt;
    fill_a2_r   <= fill_a2_nxt;
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control. The whole pipeline moves together; it may move whenever the last
  // stage is empty or the output register is free or being emptied.
  // ---------------------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic out_valid_r, out_valid_nxt;
  logic pipe_en;
  logic in_acc;

  assign pipe_en  = !v4_r || !out_valid_r || out_ready;
  assign in_ready = pipe_en && !fill_busy_r;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pipe_en && v4_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pipe_en) begin
        v1_r <= in_acc;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------------------
  // Stage 1: phases of both angles, reduced modulo a full turn.
  // ---------------------------------------------------------------------------------------
  logic [uvs_pkg::ROW_W-1:0] row1_r;
  logic [uvs_pkg::COL_W-1:0] col1_r;
  logic [ANGLE_BITS-1:0]     pst1_r, pse1_r;
  logic [PH_PROD_W-1:0]      st_prod, se_prod, st_diff;

  assign st_prod = PH_PROD_W'(in_row) * PH_PROD_W'(stack_step_r);
  assign se_prod = PH_PROD_W'(in_column) * PH_PROD_W'(sector_step_r);
  assign st_diff = QTR_PH_W - st_prod;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      row1_r <= in_row;
      col1_r <= in_column;
      pst1_r <= st_diff[ANGLE_BITS-1:0];
      pse1_r <= se_prod[ANGLE_BITS-1:0];
    end
  end

  // Folds a phase onto the quarter wave: returns the sign in the top bit and the
  // table address below it.
  function automatic logic [ANGLE_BITS-1:0] sine_lookup(input logic [ANGLE_BITS-1:0] p);
    logic [ANGLE_BITS:0] pe;
    logic [ANGLE_BITS:0] t;
    logic                neg;
    pe = {1'b0, p};
    if (pe < QTR_PH) begin
      t   = pe;
      neg = 1'b0;
    end else if (pe < HALF_PH) begin
      t   = HALF_PH - pe;
      neg = 1'b0;
    end else if (pe < HALF_PH + QTR_PH) begin
      t   = pe - HALF_PH;
      neg = 1'b1;
    end else begin
      t   = FULL_PH - pe;
      neg = 1'b1;
    end
    return {neg, t[QTR_W-1:0]};
  endfunction

  logic [ANGLE_BITS-1:0] lk_sin_st, lk_cos_st, lk_sin_se, lk_cos_se;

  assign lk_sin_st = sine_lookup(pst1_r);
  assign lk_cos_st = sine_lookup(pst1_r + QTR_PH[ANGLE_BITS-1:0]);
  assign lk_sin_se = sine_lookup(pse1_r);
  assign lk_cos_se = sine_lookup(pse1_r + QTR_PH[ANGLE_BITS-1:0]);

  // Connectivity of the grid point.
  logic [uvs_pkg::COUNT_W:0]   cols;
  logic [uvs_pkg::ROW_W+uvs_pkg::COUNT_W:0] row_start_w;
  logic [uvs_pkg::IDX_W-1:0]   row_start, upper, lower;
  logic                        col_inside, col_ok;
  uvs_pkg::mesh_idx_t          idx1;

  assign cols        = {1'b0, sectors} + (uvs_pkg::COUNT_W + 1)'(1);
  assign row_start_w = (uvs_pkg::ROW_W + uvs_pkg::COUNT_W + 1)'(row1_r) *
                       (uvs_pkg::ROW_W + uvs_pkg::COUNT_W + 1)'(cols);
  assign row_start   = row_start_w[uvs_pkg::IDX_W-1:0];
  assign upper       = row_start + uvs_pkg::IDX_W'(col1_r);
  assign lower       = upper + uvs_pkg::IDX_W'(cols);
  assign col_inside  = col1_r < sectors;
  assign col_ok      = col1_r <= sectors;

  always_comb begin
    idx1.upper_index      = upper;
    idx1.lower_index      = lower;
    idx1.upper_next       = col_inside ? upper + uvs_pkg::IDX_W'(1) : row_start;
    idx1.lower_next       = col_inside ? lower + uvs_pkg::IDX_W'(1)
                                       : row_start + uvs_pkg::IDX_W'(cols);
    idx1.top_tri_valid    = col_ok && (row1_r != '0) && (row1_r < stacks);
    idx1.bottom_tri_valid = col_ok &&
                            (({1'b0, row1_r} + (uvs_pkg::ROW_W + 1)'(1)) < {1'b0, stacks});
  end

  // ---------------------------------------------------------------------------------------
  // Sine tables. Both hold the same quarter wave; the stack table serves the two stack
  // lookups and the sector table the two sector lookups. Writes happen only during the
  // fill, when no transaction is accepted, so reads never meet a write to the same entry.
  // ---------------------------------------------------------------------------------------
  logic [uvs_pkg::MAG_W-1:0] tbl_st_mem [TBL_DEPTH];
  logic [uvs_pkg::MAG_W-1:0] tbl_se_mem [TBL_DEPTH];
  logic [uvs_pkg::MAG_W-1:0] mag_sin_st2_r, mag_cos_st2_r, mag_sin_se2_r, mag_cos_se2_r;
  logic [3:0]                neg2_r;
  uvs_pkg::mesh_idx_t        idx2_r;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_st_mem[fill_addr_r] <= prod_shr;
      tbl_se_mem[fill_addr_r] <= prod_shr;
    end
    if (pipe_en) begin
      mag_sin_st2_r <= tbl_st_mem[lk_sin_st[QTR_W-1:0]];
      mag_cos_st2_r <= tbl_st_mem[lk_cos_st[QTR_W-1:0]];
      mag_sin_se2_r <= tbl_se_mem[lk_sin_se[QTR_W-1:0]];
      mag_cos_se2_r <= tbl_se_mem[lk_cos_se[QTR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      neg2_r <= {lk_sin_st[ANGLE_BITS-1], lk_cos_st[ANGLE_BITS-1],
                 lk_sin_se[ANGLE_BITS-1], lk_cos_se[ANGLE_BITS-1]};
      idx2_r <= idx1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: signed Q30 sines and the first products.
  // ---------------------------------------------------------------------------------------
  logic signed [uvs_pkg::SIG_W-1:0] sin_st, cos_st, sin_se, cos_se;
  logic signed [uvs_pkg::RADIUS_W:0] radius_s;

  assign sin_st   = neg2_r[3] ? -$signed({1'b0, mag_sin_st2_r}) : $signed({1'b0, mag_sin_st2_r});
  assign cos_st   = neg2_r[2] ? -$signed({1'b0, mag_cos_st2_r}) : $signed({1'b0, mag_cos_st2_r});
  assign sin_se   = neg2_r[1] ? -$signed({1'b0, mag_sin_se2_r}) : $signed({1'b0, mag_sin_se2_r});
  assign cos_se   = neg2_r[0] ? -$signed({1'b0, mag_cos_se2_r}) : $signed({1'b0, mag_cos_se2_r});
  assign radius_s = $signed({1'b0, radius_r});

  logic signed [48:0]               prod_rc3_r, prod_rs3_r;
  logic signed [63:0]               prod_nx3_r, prod_ny3_r;
  logic signed [uvs_pkg::SIG_W-1:0] sin_st3_r, sin_se3_r, cos_se3_r;
  uvs_pkg::mesh_idx_t               idx3_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      prod_rc3_r <= radius_s * cos_st;
      prod_rs3_r <= radius_s * sin_st;
      prod_nx3_r <= cos_st * cos_se;
      prod_ny3_r <= cos_st * sin_se;
      sin_st3_r  <= sin_st;
      sin_se3_r  <= sin_se;
      cos_se3_r  <= cos_se;
      idx3_r     <= idx2_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: round the products (add half, then shift), the horizontal radius times the
  // sector terms, and saturation of z and of the normal.
  // ---------------------------------------------------------------------------------------
  function automatic logic [uvs_pkg::POS_W-1:0] sat_pos(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v < uvs_pkg::POS_LO) begin
      c = uvs_pkg::POS_LO;
    end else if (v > uvs_pkg::POS_HI) begin
      c = uvs_pkg::POS_HI;
    end
    return c[uvs_pkg::POS_W-1:0];
  endfunction

  function automatic logic [uvs_pkg::NORM_W-1:0] sat_norm(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v < uvs_pkg::NORM_LO) begin
      c = uvs_pkg::NORM_LO;
    end else if (v > uvs_pkg::NORM_HI) begin
      c = uvs_pkg::NORM_HI;
    end
    return c[uvs_pkg::NORM_W-1:0];
  endfunction

  logic signed [48:0]               rc_sum, rs_sum;
  logic signed [63:0]               nx_sum, ny_sum;
  logic signed [uvs_pkg::SIG_W-1:0] nz_sum;
  logic signed [uvs_pkg::SIG_W-1:0] xy;

  assign rc_sum = prod_rc3_r + (49'sd1 <<< 15);
  assign rs_sum = prod_rs3_r + (49'sd1 <<< 29);
  assign nx_sum = prod_nx3_r + (64'sd1 <<< 45);
  assign ny_sum = prod_ny3_r + (64'sd1 <<< 45);
  assign nz_sum = sin_st3_r + (32'sd1 <<< 15);
  assign xy     = $signed(rc_sum[47:16]);

  logic signed [63:0]                mul_x4_r, mul_y4_r;
  logic signed [uvs_pkg::POS_W-1:0]  pz4_r;
  logic signed [uvs_pkg::NORM_W-1:0] nx4_r, ny4_r, nz4_r;
  uvs_pkg::mesh_idx_t                idx4_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mul_x4_r <= xy * cos_se3_r;
      mul_y4_r <= xy * sin_se3_r;
      pz4_r    <= sat_pos(64'($signed(rs_sum[48:30])));
      nx4_r    <= sat_norm(64'($signed(nx_sum[63:46])));
      ny4_r    <= sat_norm(64'($signed(ny_sum[63:46])));
      nz4_r    <= sat_norm(64'($signed(nz_sum[31:16])));
      idx4_r   <= idx3_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 4: round and saturate x and y, then the output register.
  // ---------------------------------------------------------------------------------------
  logic signed [63:0] px_sum, py_sum;

  assign px_sum = mul_x4_r + (64'sd1 <<< 43);
  assign py_sum = mul_y4_r + (64'sd1 <<< 43);

  always_ff @(posedge clk) begin
    if (pipe_en && v4_r) begin
      out_pos_x            <= sat_pos(64'($signed(px_sum[63:44])));
      out_pos_y            <= sat_pos(64'($signed(py_sum[63:44])));
      out_pos_z            <= pz4_r;
      out_norm_x           <= nx4_r;
      out_norm_y           <= ny4_r;
      out_norm_z           <= nz4_r;
      out_upper_index      <= idx4_r.upper_index;
      out_lower_index      <= idx4_r.lower_index;
      out_upper_next       <= idx4_r.upper_next;
      out_lower_next       <= idx4_r.lower_next;
      out_top_tri_valid    <= idx4_r.top_tri_valid;
      out_bottom_tri_valid <= idx4_r.bottom_tri_valid;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------------------
  // No grid point enters while the tables are still being filled.
  `UVS_ASSERT_NOW(a_no_accept_in_fill, clk, rst_n, fill_busy_r, !in_ready)
  // Table writes belong to the fill only.
  `UVS_ASSERT_NOW(a_write_only_in_fill, clk, rst_n, tbl_we, fill_busy_r)
  // Once the fill has finished it never starts again.
  `UVS_ASSERT_NEXT(a_fill_done_sticks, clk, rst_n, !fill_busy_r, !fill_busy_r)
  // A result in the last stage is not lost while the output register is stalled.
  `UVS_ASSERT_NEXT(a_last_stage_held, clk, rst_n, v4_r && out_valid_r && !out_ready,
                   v4_r && out_valid_r)
  // The fill sequencer never leaves its seven steps.
  `UVS_ASSERT_NOW(a_fill_step_range, clk, rst_n, fill_busy_r, fill_step_r <= FS_WRITE)

endmodule

FILE: bench/tb_uv_sphere_mesh_generator.sv
module tb_uv_sphere_mesh_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import uvs_pkg::*;

  // Block configuration. These match the defaults of the generator and are passed to it, so
  // the local predictor and the device always agree on the grid limits and the phase width.
  localparam int MAX_SECTORS = 256;
  localparam int MAX_STACKS  = 256;
  localparam int ANGLE_BITS  = 16;

  localparam int CLK_PERIOD   = 10;
  localparam int PIPE_LATENCY = 5;

  // The generator fills its sine table after reset before it takes a point. The limit
  // covers that pass plus every grid point meeting the longest input gap, the longest
  // output stall and the pipeline latency, taken about three times over.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Random part of the run: a number of register settings, each with a block of points.
  localparam int RAND_SETTINGS      = 10;
  localparam int POINTS_PER_SETTING = 143;

  // A register index with no register behind it. Writes there must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [31:0] PHASE_MASK    = 32'((64'd1 << ANGLE_BITS) - 1);
  localparam logic [31:0] QUARTER_PHASE = 32'd1 << (ANGLE_BITS - 2);

  // One grid point as the sender presents it.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } grid_point_t;

  // One vertex transaction as the generator returns it.
  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    mesh_idx_t                mesh;
  } vertex_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [ROW_W-1:0] in_row    = '0;
  logic [COL_W-1:0] in_column = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [POS_W-1:0]  out_pos_x;
  logic signed [POS_W-1:0]  out_pos_y;
  logic signed [POS_W-1:0]  out_pos_z;
  logic signed [NORM_W-1:0] out_norm_x;
  logic signed [NORM_W-1:0] out_norm_y;
  logic signed [NORM_W-1:0] out_norm_z;
  logic [IDX_W-1:0]         out_upper_index;
  logic [IDX_W-1:0]         out_lower_index;
  logic [IDX_W-1:0]         out_upper_next;
  logic [IDX_W-1:0]         out_lower_next;
  logic                     out_top_tri_valid;
  logic                     out_bottom_tri_valid;

  // Shadow copy of the configuration registers, updated at the edge that writes each one.
  logic [RADIUS_W-1:0] sh_radius      = RADIUS_RST;
  logic [COUNT_W-1:0]  sh_sectors     = SECTORS_RST;
  logic [COUNT_W-1:0]  sh_stacks      = STACKS_RST;
  logic [STEP_W-1:0]   sh_sector_step = SECTOR_STEP_RST;
  logic [STEP_W-1:0]   sh_stack_step  = STACK_STEP_RST;

  grid_point_t pending_points[$];  // filled by the stimulus, drained by the driver
  vertex_t     due_vertices[$];    // predicted vertices, oldest first

  int unsigned points_queued  = 0;
  int unsigned vertices_seen  = 0;
  int unsigned mismatches     = 0;
  int unsigned settings_used  = 1;
  int unsigned cycle_count    = 0;

  // Idle control shared by the two channel drivers. When the enables are clear the
  // channels run flat out, which gives stretches of back-to-back transactions.
  bit          in_gaps_on     = 1'b1;
  bit          out_stalls_on  = 1'b1;
  int unsigned in_gap_left    = 0;
  int unsigned out_stall_left = 0;
  bit          in_taken       = 1'b0;

  uv_sphere_mesh_generator #(
    .MAX_SECTORS(MAX_SECTORS),
    .MAX_STACKS (MAX_STACKS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_row              (in_row),
    .in_column           (in_column),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pos_x           (out_pos_x),
    .out_pos_y           (out_pos_y),
    .out_pos_z           (out_pos_z),
    .out_norm_x          (out_norm_x),
    .out_norm_y          (out_norm_y),
    .out_norm_z          (out_norm_z),
    .out_upper_index     (out_upper_index),
    .out_lower_index     (out_lower_index),
    .out_upper_next      (out_upper_next),
    .out_lower_next      (out_lower_next),
    .out_top_tri_valid   (out_top_tri_valid),
    .out_bottom_tri_valid(out_bottom_tri_valid)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Vertex predictor
  // ---------------------------------------------------------------------------------------

  // Quarter-wave polynomial sine of a 32-bit phase, Q30 result. Every product is floored
  // back to Q30 before the next Horner step, exactly as the hardware table is built.
  function automatic longint q30_sine(input logic [31:0] phase);
    longint          t;
    longint unsigned mag;
    longint unsigned mag_sq;
    longint unsigned acc;
    if (phase < 32'h4000_0000) begin
      t = longint'({32'd0, phase});
    end else if (phase < 32'hC000_0000) begin
      t = 64'sh8000_0000 - longint'({32'd0, phase});
    end else begin
      t = longint'({32'd0, phase}) - 64'sh1_0000_0000;
    end
    mag    = (t < 0) ? -t : t;
    mag_sq = (mag * mag) >> FRAC;
    acc    = C9;
    acc    = C7 - ((acc * mag_sq) >> FRAC);
    acc    = C5 - ((acc * mag_sq) >> FRAC);
    acc    = C3 - ((acc * mag_sq) >> FRAC);
    acc    = C1 - ((acc * mag_sq) >> FRAC);
    acc    = (acc * mag) >> FRAC;
    return (t < 0) ? -longint'(acc) : longint'(acc);
  endfunction

  // Round half up, then drop the fraction bits.
  function automatic longint round_sh(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // A count register of zero behaves as one, anything above the maximum as the maximum.
  function automatic int unsigned eff_count(input logic [COUNT_W-1:0] v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic vertex_t predict_vertex(input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] column);
    vertex_t     v;
    logic [31:0] ph_st;
    logic [31:0] ph_se;
    longint      sin_st;
    longint      cos_st;
    longint      sin_se;
    longint      cos_se;
    longint      rad;
    longint      xy;
    int unsigned sectors;
    int unsigned stacks;
    int unsigned cols;
    int unsigned row_start;
    int unsigned upper;
    int unsigned lower;
    // Stack angle counts down from the north pole, sector angle counts up from zero.
    ph_st  = (QUARTER_PHASE - row * sh_stack_step) & PHASE_MASK;
    ph_st  = ph_st << (32 - ANGLE_BITS);
    ph_se  = (column * sh_sector_step) & PHASE_MASK;
    ph_se  = ph_se << (32 - ANGLE_BITS);
    sin_st = q30_sine(ph_st);
    cos_st = q30_sine(ph_st + 32'h4000_0000);
    sin_se = q30_sine(ph_se);
    cos_se = q30_sine(ph_se + 32'h4000_0000);

    rad      = longint'(sh_radius);
    xy       = round_sh(rad * cos_st, 16);
    v.pos_x  = POS_W'(saturate(round_sh(xy * cos_se, 44), POS_LO, POS_HI));
    v.pos_y  = POS_W'(saturate(round_sh(xy * sin_se, 44), POS_LO, POS_HI));
    v.pos_z  = POS_W'(saturate(round_sh(rad * sin_st, 30), POS_LO, POS_HI));
    v.norm_x = NORM_W'(saturate(round_sh(cos_st * cos_se, 46), NORM_LO, NORM_HI));
    v.norm_y = NORM_W'(saturate(round_sh(cos_st * sin_se, 46), NORM_LO, NORM_HI));
    v.norm_z = NORM_W'(saturate(round_sh(sin_st, 16), NORM_LO, NORM_HI));

    // Each row holds sectors + 1 vertices; the seam column repeats the first one.
    sectors   = eff_count(sh_sectors, MAX_SECTORS);
    stacks    = eff_count(sh_stacks, MAX_STACKS);
    cols      = sectors + 1;
    row_start = row * cols;
    upper     = row_start + column;
    lower     = upper + cols;
    v.mesh.upper_index      = IDX_W'(upper);
    v.mesh.lower_index      = IDX_W'(lower);
    v.mesh.upper_next       = IDX_W'((column < sectors) ? upper + 1 : row_start);
    v.mesh.lower_next       = IDX_W'((column < sectors) ? lower + 1 : row_start + cols);
    v.mesh.top_tri_valid    = (column <= sectors) && (row != 0) && (row < stacks);
    v.mesh.bottom_tri_valid = (column <= sectors) && (row + 1 < stacks);
    return v;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Channel drivers and monitor
  // ---------------------------------------------------------------------------------------

  // Most gaps are short; now and then a long one lets the pipeline empty or fill up.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Input driver. A presented grid point is held until the monitor reports it taken; only
  // then may the driver idle for a while or present the next point from the queue.
  always @(negedge clk) begin : drive_points
    grid_point_t pt;
    logic        next_valid;
    next_valid = in_valid;
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap_left != 0) begin
        in_gap_left--;
        next_valid = 1'b0;
      end else if (pending_points.size() != 0) begin
        pt         = pending_points.pop_front();
        in_row    <= pt.row;
        in_column <= pt.column;
        next_valid = 1'b1;
        in_gap_left = in_gaps_on ? draw_gap() : 0;
      end else begin
        next_valid = 1'b0;
      end
    end
    in_valid <= next_valid;
  end

  // Output back-pressure. While a stall runs the generator must hold its result.
  always @(negedge clk) begin : drive_ready
    logic next_ready;
    if (out_stall_left != 0) begin
      out_stall_left--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
      if (out_stalls_on && $urandom_range(0, 2) == 0) out_stall_left = draw_gap();
    end
    out_ready <= next_ready;
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor. Both handshakes are sampled at the rising edge. An accepted grid point is
  // predicted right away against the shadow registers, which cannot change while points
  // are in flight; an accepted vertex is compared with the oldest prediction.
  always @(posedge clk) begin : watch_channels
    vertex_t got;
    vertex_t want;
    if (rst_n && in_valid && in_ready) begin
      due_vertices.push_back(predict_vertex(in_row, in_column));
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      vertices_seen++;
      got.pos_x                 = out_pos_x;
      got.pos_y                 = out_pos_y;
      got.pos_z                 = out_pos_z;
      got.norm_x                = out_norm_x;
      got.norm_y                = out_norm_y;
      got.norm_z                = out_norm_z;
      got.mesh.upper_index      = out_upper_index;
      got.mesh.lower_index      = out_lower_index;
      got.mesh.upper_next       = out_upper_next;
      got.mesh.lower_next       = out_lower_next;
      got.mesh.top_tri_valid    = out_top_tri_valid;
      got.mesh.bottom_tri_valid = out_bottom_tri_valid;
      if (due_vertices.size() == 0) begin
        $display("%0t ns: vertex transaction with no grid point outstanding, upper_index %0d",
                 $time, out_upper_index);
        mismatches++;
      end else begin
        want = due_vertices.pop_front();
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("pos_z", want.pos_z, got.pos_z);
        check_field("norm_x", want.norm_x, got.norm_x);
        check_field("norm_y", want.norm_y, got.norm_y);
        check_field("norm_z", want.norm_z, got.norm_z);
        check_field("upper_index", want.mesh.upper_index, got.mesh.upper_index);
        check_field("lower_index", want.mesh.lower_index, got.mesh.lower_index);
        check_field("upper_next", want.mesh.upper_next, got.mesh.upper_next);
        check_field("lower_next", want.mesh.lower_next, got.mesh.lower_next);
        check_field("top_tri_valid", want.mesh.top_tri_valid, got.mesh.top_tri_valid);
        check_field("bottom_tri_valid", want.mesh.bottom_tri_valid,
                    got.mesh.bottom_tri_valid);
      end
    end
  end

  // Watchdog. A lost vertex or a stuck handshake ends the run here.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: run stopped after %0d cycles, %0d vertices still due",
               $time, cycle_count, due_vertices.size());
      $display("uv_sphere_mesh_generator: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Configuration and stimulus
  // ---------------------------------------------------------------------------------------

  // One APB write: setup cycle, then access cycle until pready. The task starts and ends at
  // a falling edge and leaves psel high, so writes can follow each other without a gap;
  // cfg_release closes a burst. The upper data bits carry noise the block must ignore.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] field);
    logic [CFG_DATA_W-1:0] data;
    data = {16'($urandom()), field};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_RADIUS:      sh_radius      = data[RADIUS_W-1:0];
      REG_SECTORS:     sh_sectors     = data[COUNT_W-1:0];
      REG_STACKS:      sh_stacks      = data[COUNT_W-1:0];
      REG_SECTOR_STEP: sh_sector_step = data[STEP_W-1:0];
      REG_STACK_STEP:  sh_stack_step  = data[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic cfg_release();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] radius, input logic [15:0] sectors,
                              input logic [15:0] stacks, input logic [15:0] sector_step,
                              input logic [15:0] stack_step);
    write_reg(REG_RADIUS, radius);
    write_reg(REG_SECTORS, sectors);
    write_reg(REG_STACKS, stacks);
    write_reg(REG_SECTOR_STEP, sector_step);
    write_reg(REG_STACK_STEP, stack_step);
    cfg_release();
    settings_used++;
  endtask

  task automatic queue_point(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column);
    grid_point_t pt;
    pt.row    = row;
    pt.column = column;
    pending_points.push_back(pt);
    points_queued++;
  endtask

  // Holds the sender off until every queued point has come back as a vertex. Called at a
  // falling edge; the vertex count only moves at rising edges, so the test is race free.
  task automatic wait_drained();
    while (vertices_seen < points_queued) @(negedge clk);
  endtask

  // A batch walks the mesh the way a renderer would: either a raster sweep from a random
  // start, wrapping at the seam and at the south pole, or scattered points on the grid.
  // About one point in seven is noise over the whole 9-bit range of both fields.
  task automatic queue_batch(input int n);
    int unsigned sectors;
    int unsigned stacks;
    int unsigned r;
    int unsigned c;
    bit          sweep;
    sectors = eff_count(sh_sectors, MAX_SECTORS);
    stacks  = eff_count(sh_stacks, MAX_STACKS);
    sweep   = $urandom_range(0, 1);
    r       = $urandom_range(0, stacks);
    c       = $urandom_range(0, sectors);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        queue_point($urandom_range(0, 2**ROW_W - 1), $urandom_range(0, 2**COL_W - 1));
      end else if (sweep) begin
        queue_point(r, c);
        c++;
        if (c > sectors) begin
          c = 0;
          r = (r >= stacks) ? 0 : r + 1;
        end
      end else begin
        queue_point($urandom_range(0, stacks), $urandom_range(0, sectors));
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] radius;
    logic [15:0] sectors;
    logic [15:0] stacks;
    logic [15:0] sector_step;
    logic [15:0] stack_step;
    int          left;
    int          batch;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: 36 sectors, 18 stacks, unit radius. Both poles, the seam column, the
    // column past the seam, the row at and past the last stack and all-ones fields. The
    // first point waits out the table fill after reset.
    queue_point(0, 0);
    queue_point(0, 1);
    queue_point(1, 0);
    queue_point(9, 9);
    queue_point(17, 35);
    queue_point(17, 36);
    queue_point(1, 36);
    queue_point(18, 0);
    queue_point(19, 37);
    queue_point(511, 511);
    queue_point(256, 256);
    queue_point(341, 170);
    wait_drained();

    // Zero radius with both counts at zero (taken as one) and a stack step that wraps by
    // almost a full turn. The write to the empty register index must change nothing.
    write_reg(REG_UNUSED, 16'hFFFF);
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    queue_point(0, 0);
    queue_point(0, 1);
    queue_point(1, 1);
    queue_point(2, 0);
    queue_point(300, 7);
    wait_drained();

    // Full-scale radius saturates the positions; counts above the maximum are clipped and a
    // half-turn stack step jumps from pole to pole.
    program_regs(16'hFFFF, 16'd511, 16'd300, 16'd16384, 16'd32768);
    queue_point(0, 0);
    queue_point(1, 0);
    queue_point(255, 256);
    queue_point(256, 256);
    queue_point(2, 64);
    queue_point(3, 255);
    wait_drained();

    // Random settings, extremes included. Each setting is split into batches and the sender
    // holds off at the end of every batch until all vertices are back, so the pipeline runs
    // both full and completely empty.
    for (int s = 0; s < RAND_SETTINGS; s++) begin
      case ($urandom_range(0, 4))
        0:       radius = 16'd0;
        1:       radius = 16'hFFFF;
        2:       radius = 16'd4096;
        default: radius = $urandom_range(0, 16'hFFFF);
      endcase
      case ($urandom_range(0, 6))
        0:       sectors = 16'd0;
        1:       sectors = 16'd1;
        2:       sectors = 16'd256;
        3:       sectors = $urandom_range(257, 511);
        default: sectors = $urandom_range(2, 40);
      endcase
      case ($urandom_range(0, 6))
        0:       stacks = 16'd0;
        1:       stacks = 16'd1;
        2:       stacks = 16'd256;
        3:       stacks = $urandom_range(257, 511);
        default: stacks = $urandom_range(2, 40);
      endcase
      case ($urandom_range(0, 4))
        0:       sector_step = 16'd0;
        1:       sector_step = 16'hFFFF;
        2:       sector_step = 16'(65536 / eff_count(sectors[COUNT_W-1:0], MAX_SECTORS));
        default: sector_step = $urandom_range(0, 16'hFFFF);
      endcase
      case ($urandom_range(0, 5))
        0:       stack_step = 16'd0;
        1:       stack_step = 16'd32768;
        2:       stack_step = 16'hFFFF;
        3:       stack_step = 16'(32768 / eff_count(stacks[COUNT_W-1:0], MAX_STACKS));
        default: stack_step = $urandom_range(0, 16'hFFFF);
      endcase
      program_regs(radius, sectors, stacks, sector_step, stack_step);

      left = POINTS_PER_SETTING;
      while (left > 0) begin
        batch         = $urandom_range(20, 80);
        batch         = (batch > left) ? left : batch;
        in_gaps_on    = ($urandom_range(0, 3) != 0);
        out_stalls_on = ($urandom_range(0, 3) != 0);
        queue_batch(batch);
        wait_drained();
        left -= batch;
      end
    end

    // Give a stray extra vertex time to show up before the verdict.
    repeat (2 * PIPE_LATENCY) @(negedge clk);
    if (due_vertices.size() != 0) begin
      $display("%0t ns: %0d predicted vertices never arrived", $time, due_vertices.size());
      mismatches++;
    end

    $display("Sent %0d grid points under %0d register settings and checked %0d vertices.",
             points_queued, settings_used, vertices_seen);
    $display("Settings spanned zero and full radius, clipped counts and wrapping steps.");
    if (mismatches == 0) begin
      $display("uv_sphere_mesh_generator: match");
    end else begin
      $display("uv_sphere_mesh_generator: mismatch");
    end
    $finish;
  end

endmodule

FILE: uv_sphere_mesh_generator.f
+incdir+rtl
rtl/uvs_pkg.sv
rtl/uv_sphere_mesh_generator.sv
bench/tb_uv_sphere_mesh_generator.sv
